// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the directory lookup rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dlk_pkg.sv -----
// shared types and constants of the directory lookup block
package dlk_pkg;

    localparam int unsigned SECTOR_DATA_BYTES   = 2048;
    localparam int unsigned SECTOR_BITS         = $clog2(SECTOR_DATA_BYTES);
    localparam int unsigned NAME_STORE_DEPTH    = 256;
    localparam int unsigned NAME_ADDR_BITS      = $clog2(NAME_STORE_DEPTH);
    localparam int unsigned MAX_COMPONENT_CHARS = 32;
    localparam int unsigned COMP_IDX_BITS       = $clog2(MAX_COMPONENT_CHARS);

    localparam logic [7:0] MIN_RECORD_LEN = 8'd34;
    localparam logic [7:0] NAME_FIELD_POS = 8'd33;
    localparam logic [7:0] CH_SEMI        = 8'h3B;
    localparam logic [7:0] CH_ONE         = 8'h31;
    localparam logic [7:0] CH_SPACE       = 8'h20;

    typedef enum logic [1:0]
    {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_BAD       = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        REG_CHARS_A = 3'd0,
        REG_CHARS_B = 3'd1,
        REG_CHARS_C = 3'd2,
        REG_CHARS_D = 3'd3,
        REG_LENGTH  = 3'd4,
        REG_DIRSIZE = 3'd5
    } reg_idx_t;

    typedef struct packed
    {
        logic [63:0] chars_d;
        logic [63:0] chars_c;
        logic [63:0] chars_b;
        logic [63:0] chars_a;
        logic [5:0]  comp_len;
        logic [30:0] dir_size;
    } cfg_t;

    function automatic logic [7:0] upper_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/dlk_cfg_regs.sv -----
// apb configuration registers of the directory lookup
module dlk_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output dlk_pkg::cfg_t cfg
);
    import dlk_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_CHARS_A: cfg_next.chars_a  = pwdata;
                REG_CHARS_B: cfg_next.chars_b  = pwdata;
                REG_CHARS_C: cfg_next.chars_c  = pwdata;
                REG_CHARS_D: cfg_next.chars_d  = pwdata;
                REG_LENGTH:  cfg_next.comp_len = pwdata[5:0];
                REG_DIRSIZE: cfg_next.dir_size = pwdata[30:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg          <= '0;
            cfg_reg.comp_len <= 6'd1;
            cfg_reg.dir_size <= 31'd2048;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            REG_CHARS_A: prdata = cfg_reg.chars_a;
            REG_CHARS_B: prdata = cfg_reg.chars_b;
            REG_CHARS_C: prdata = cfg_reg.chars_c;
            REG_CHARS_D: prdata = cfg_reg.chars_d;
            REG_LENGTH:  prdata = {58'd0, cfg_reg.comp_len};
            REG_DIRSIZE: prdata = {33'd0, cfg_reg.dir_size};
            default:     prdata = 64'd0;
        endcase
    end

endmodule

// ----- rtl/core/dlk_name_ram.sv -----
// name store memory, one write and one registered read port
module dlk_name_ram
(
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [dlk_pkg::NAME_ADDR_BITS-1:0] wr_addr,
    input  logic [7:0]                         wr_data,
    input  logic [dlk_pkg::NAME_ADDR_BITS-1:0] rd_addr,
    output logic [7:0]                         rd_data
);
    import dlk_pkg::*;

    logic [7:0] mem [NAME_STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/iso9660_directory_lookup.sv -----
// directory record lookup: byte scanner, name store and name compare
// result: registered, shown the cycle after the deciding word, or after the name compare
// when a record end starts one (one stored byte read per cycle)
// throughput: one word per cycle; words stall during the name compare and while a result waits for out_ready
// reset: asynchronous active low, scan idle, control registers at their reset values; held fields and payload not reset
module iso9660_directory_lookup
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_scan,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  scan_status,
    output logic [31:0] extent_lba,
    output logic [31:0] extent_size,
    output logic [7:0]  file_flags
);
    `include "assert_macros.svh"
    import dlk_pkg::*;

    typedef enum logic [1:0]
    {
        ST_RUN = 2'b01,
        ST_CMP = 2'b10
    } state_t;

    cfg_t cfg;

    dlk_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t      state_reg, state_next;
    logic        active_reg, active_next;
    logic        skip_reg, skip_next;
    logic [30:0] off_reg, off_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  rl_reg, rl_next;
    logic [31:0] lba_reg, lba_next;
    logic [31:0] size_reg, size_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  nl_reg, nl_next;
    logic [7:0]  trim_reg, trim_next;
    logic [7:0]  last_reg, last_next;
    logic [7:0]  before_reg, before_next;
    logic [7:0]  prev_reg, prev_next;
    logic [5:0]  idx_reg, idx_next;
    logic        dv_reg, dv_next;
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [31:0] olba_reg, olba_next;
    logic [31:0] osize_reg, osize_next;
    logic [7:0]  oflags_reg, oflags_next;

    logic                      acc;
    logic                      ram_we;
    logic [NAME_ADDR_BITS-1:0] ram_waddr;
    logic [NAME_ADDR_BITS-1:0] ram_raddr;
    logic [7:0]                ram_rdata;

    dlk_name_ram u_ram
    (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (data_byte),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign acc       = in_valid && in_ready;
    assign ram_raddr = NAME_ADDR_BITS'(idx_reg);

    // component byte select and trimmed lengths
    logic [255:0]             comp_all;
    logic [5:0]               clen_sat;
    logic [5:0]               clen_trim;
    logic [7:0]               rlen_trim;
    logic [COMP_IDX_BITS-1:0] c_i1, c_i2;
    logic [5:0]               j_idx;
    logic [7:0]               comp_j;

    assign comp_all  = {cfg.chars_d, cfg.chars_c, cfg.chars_b, cfg.chars_a};
    assign clen_sat  = (cfg.comp_len > 6'(MAX_COMPONENT_CHARS)) ?
                       6'(MAX_COMPONENT_CHARS) : cfg.comp_len;
    assign c_i1      = COMP_IDX_BITS'(clen_sat - 6'd1);
    assign c_i2      = COMP_IDX_BITS'(clen_sat - 6'd2);
    assign clen_trim = (clen_sat > 6'd2 && comp_all[c_i2*8 +: 8] == CH_SEMI &&
                        comp_all[c_i1*8 +: 8] == CH_ONE) ? clen_sat - 6'd2 : clen_sat;
    assign rlen_trim = (trim_reg > 8'd2 && before_reg == CH_SEMI && last_reg == CH_ONE) ?
                       trim_reg - 8'd2 : trim_reg;
    assign j_idx     = idx_reg - 6'd1;
    assign comp_j    = comp_all[COMP_IDX_BITS'(j_idx)*8 +: 8];

    // scan and compare control
    always_comb
    begin
        logic        e_active;
        logic        e_skip;
        logic [30:0] e_off;
        logic [7:0]  e_pos;
        logic [7:0]  e_rl;
        logic [31:0] off32;
        logic [31:0] size32;
        logic [31:0] bnd;
        logic [31:0] off_inc;
        logic [8:0]  pinc;
        logic [7:0]  nidx;
        logic        fin;
        logic        go_cmp;
        logic        done;
        logic        match;
        status_t     fst;

        state_next     = state_reg;
        active_next    = active_reg;
        skip_next      = skip_reg;
        off_next       = off_reg;
        pos_next       = pos_reg;
        rl_next        = rl_reg;
        lba_next       = lba_reg;
        size_next      = size_reg;
        flags_next     = flags_reg;
        nl_next        = nl_reg;
        trim_next      = trim_reg;
        last_next      = last_reg;
        before_next    = before_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        dv_next        = dv_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        fin            = 1'b0;
        go_cmp         = 1'b0;
        fst            = STATUS_NOT_FOUND;
        done           = 1'b0;
        match          = 1'b0;
        e_active       = active_reg;
        e_skip         = skip_reg;
        e_off          = off_reg;
        e_pos          = pos_reg;
        e_rl           = rl_reg;
        size32         = {1'b0, cfg.dir_size};
        off32          = '0;
        bnd            = '0;
        off_inc        = '0;
        pinc           = '0;
        nidx           = '0;

        if (state_reg == ST_RUN && acc)
        begin
            if (start_scan)
            begin
                e_active   = 1'b1;
                e_skip     = 1'b0;
                e_off      = '0;
                e_pos      = '0;
                e_rl       = '0;
                lba_next   = '0;
                size_next  = '0;
                flags_next = '0;
                nl_next    = '0;
            end
            active_next = e_active;
            skip_next   = e_skip;
            off_next    = e_off;
            pos_next    = e_pos;
            rl_next     = e_rl;
            off32       = {1'b0, e_off};
            bnd         = (off32 | 32'(SECTOR_DATA_BYTES - 1)) + 32'd1;
            if (e_active)
            begin
                if (e_skip)
                begin
                    // word dropped until the sector boundary
                end
                else if (e_pos == 8'd0)
                begin
                    if (off32 >= size32)
                    begin
                        fin = 1'b1;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        if (bnd >= size32)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                    else if (data_byte < MIN_RECORD_LEN ||
                             off32 + {24'd0, data_byte} > size32)
                    begin
                        fin = 1'b1;
                        fst = STATUS_BAD;
                    end
                    else
                    begin
                        rl_next  = data_byte;
                        pos_next = 8'd1;
                    end
                end
                else
                begin
                    // field capture by record position
                    case (e_pos)
                        8'd2:  lba_next = {24'd0, data_byte};
                        8'd3:  lba_next[15:8] = data_byte;
                        8'd4:  lba_next[23:16] = data_byte;
                        8'd5:  lba_next[31:24] = data_byte;
                        8'd10: size_next = {24'd0, data_byte};
                        8'd11: size_next[15:8] = data_byte;
                        8'd12: size_next[23:16] = data_byte;
                        8'd13: size_next[31:24] = data_byte;
                        8'd25: flags_next = data_byte;
                        8'd32:
                        begin
                            nl_next   = data_byte;
                            trim_next = 8'd0;
                        end
                        default:
                        begin
                            if (e_pos >= NAME_FIELD_POS)
                            begin
                                nidx      = e_pos - NAME_FIELD_POS;
                                ram_we    = 1'b1;
                                ram_waddr = NAME_ADDR_BITS'(nidx);
                                prev_next = data_byte;
                                if (nidx < nl_reg && data_byte != CH_SPACE)
                                begin
                                    trim_next   = nidx + 8'd1;
                                    last_next   = data_byte;
                                    before_next = prev_reg;
                                end
                            end
                        end
                    endcase
                    pinc = {1'b0, e_pos} + 9'd1;
                    if (pinc >= {1'b0, e_rl})
                    begin
                        pos_next = 8'd0;
                        if ({1'b0, nl_next} + {1'b0, NAME_FIELD_POS} <= {1'b0, e_rl})
                        begin
                            go_cmp = 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = pinc[7:0];
                    end
                end
                if (!fin)
                begin
                    off_inc  = off32 + 32'd1;
                    off_next = off_inc[30:0];
                    if (skip_next && off_inc[SECTOR_BITS-1:0] == '0)
                    begin
                        skip_next = 1'b0;
                    end
                    if (!go_cmp && !skip_next && pos_next == 8'd0 && off_inc >= size32)
                    begin
                        fin = 1'b1;
                    end
                end
                if (go_cmp && !fin)
                begin
                    state_next = ST_CMP;
                    idx_next   = '0;
                    dv_next    = 1'b0;
                end
            end
        end
        else if (state_reg == ST_CMP)
        begin
            // one stored name byte checked per cycle
            idx_next = idx_reg + 6'd1;
            dv_next  = 1'b1;
            if (rlen_trim != {2'd0, clen_trim})
            begin
                done = 1'b1;
            end
            else if (clen_trim == 6'd0)
            begin
                done  = 1'b1;
                match = 1'b1;
            end
            else if (dv_reg)
            begin
                if (upper_ascii(ram_rdata) != upper_ascii(comp_j))
                begin
                    done = 1'b1;
                end
                else if (j_idx == clen_trim - 6'd1)
                begin
                    done  = 1'b1;
                    match = 1'b1;
                end
            end
            if (done)
            begin
                state_next = ST_RUN;
                if (match)
                begin
                    fin = 1'b1;
                    fst = STATUS_FOUND;
                end
                else if ({1'b0, off_reg} >= size32)
                begin
                    fin = 1'b1;
                end
            end
        end

        if (fin)
        begin
            active_next = 1'b0;
            skip_next   = 1'b0;
            pos_next    = 8'd0;
        end

        // result register
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        olba_next      = olba_reg;
        osize_next     = osize_reg;
        oflags_next    = oflags_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
            status_next    = fst;
            olba_next      = (fst == STATUS_FOUND) ? lba_reg : 32'd0;
            osize_next     = (fst == STATUS_FOUND) ? size_reg : 32'd0;
            oflags_next    = (fst == STATUS_FOUND) ? flags_reg : 8'd0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            active_reg    <= 1'b0;
            skip_reg      <= 1'b0;
            off_reg       <= '0;
            pos_reg       <= '0;
            rl_reg        <= '0;
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            skip_reg      <= skip_next;
            off_reg       <= off_next;
            pos_reg       <= pos_next;
            rl_reg        <= rl_next;
            idx_reg       <= idx_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // held fields and result payload
    always_ff @(posedge clk)
    begin
        lba_reg    <= lba_next;
        size_reg   <= size_next;
        flags_reg  <= flags_next;
        nl_reg     <= nl_next;
        trim_reg   <= trim_next;
        last_reg   <= last_next;
        before_reg <= before_next;
        prev_reg   <= prev_next;
        status_reg <= status_next;
        olba_reg   <= olba_next;
        osize_reg  <= osize_next;
        oflags_reg <= oflags_next;
    end

    assign out_valid   = out_valid_reg;
    assign scan_status = status_reg;
    assign extent_lba  = olba_reg;
    assign extent_size = osize_reg;
    assign file_flags  = oflags_reg;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(scan_status), "result dropped while stalled")
    `ASSERT_ALWAYS(a_status_code, clk, rst_n, !out_valid || scan_status != 2'd3, "bad status code")
    `ASSERT_ALWAYS(a_cmp_between, clk, rst_n, state_reg != ST_CMP || (pos_reg == 8'd0 && !skip_reg), "compare inside record")
    `ASSERT_ALWAYS(a_zero_fields, clk, rst_n, !out_valid || status_reg == STATUS_FOUND || (extent_lba == 32'd0 && file_flags == 8'd0), "fields set without match")

endmodule

// ----- tb/tb_iso9660_directory_lookup.sv -----
// testbench for the directory record lookup: directed rows, random directories, self-checking
`timescale 1ns / 1ps

module tb_iso9660_directory_lookup;
    import dlk_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed
    {
        status_t     st;
        logic [31:0] lba;
        logic [31:0] size;
        logic [7:0]  flags;
    } lookup_t;

    typedef struct
    {
        bit          is_size;
        logic [30:0] size_val;
        logic [7:0]  b;
        bit          s;
        bit          typed;
        status_t     st;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_scan;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  scan_status;
    logic [31:0] extent_lba;
    logic [31:0] extent_size;
    logic [7:0]  file_flags;

    iso9660_directory_lookup dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .start_scan  (start_scan),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scan_status (scan_status),
        .extent_lba  (extent_lba),
        .extent_size (extent_size),
        .file_flags  (file_flags)
    );

    // predictor copy of the configuration
    logic [255:0] m_chars;
    logic [5:0]   m_clen;
    logic [30:0]  m_dsize;

    // predictor copy of the scan state
    logic [30:0] m_off;
    logic [7:0]  m_pos;
    logic [7:0]  m_rlen;
    logic [31:0] m_lba;
    logic [31:0] m_size;
    logic [7:0]  m_flags;
    logic [7:0]  m_nlen;
    logic [7:0]  m_names [256];
    bit          m_skip;
    bit          m_active;

    // words waiting to be sent and lookups waiting to come out
    logic [7:0] tx_byte_q [$];
    bit         tx_start_q [$];
    lookup_t    lookup_q [$];

    int  n_errors;
    int  n_bytes;
    int  n_lookups;
    int  n_found;
    int  n_scans;
    int  n_phases;
    int  cycles;
    bit  calm;
    bit  hold_req;
    bit  hold_done;

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("iso9660_directory_lookup regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] comp_char(input int i);
        return m_chars[i*8 +: 8];
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "a" && c <= "z")
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // trimmed, case-folded compare of the stored record name with the component
    function automatic bit name_hit();
        int rl;
        int cl;
        rl = m_nlen;
        cl = (m_clen > MAX_COMPONENT_CHARS) ? MAX_COMPONENT_CHARS : m_clen;
        while (rl > 0 && m_names[rl-1] == CH_SPACE)
        begin
            rl--;
        end
        if (rl > 2 && m_names[rl-2] == CH_SEMI && m_names[rl-1] == CH_ONE)
        begin
            rl -= 2;
        end
        if (cl > 2 && comp_char(cl-2) == CH_SEMI && comp_char(cl-1) == CH_ONE)
        begin
            cl -= 2;
        end
        if (rl != cl)
        begin
            return 1'b0;
        end
        for (int i = 0; i < cl; i++)
        begin
            if (fold_case(m_names[i]) != fold_case(comp_char(i)))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit close_scan(input status_t st, input bit with_fields,
                                      output lookup_t r);
        r.st    = st;
        r.lba   = with_fields ? m_lba : 32'd0;
        r.size  = with_fields ? m_size : 32'd0;
        r.flags = with_fields ? m_flags : 8'd0;
        m_active = 1'b0;
        m_skip   = 1'b0;
        m_pos    = 8'd0;
        return 1'b1;
    endfunction

    // one directory word through the predictor; returns 1 when a lookup ends
    function automatic bit predict_lookup(input logic [7:0] b, input bit s, output lookup_t r);
        longint off;
        longint sz;
        longint bnd;
        int     p;
        r = '0;
        if (s)
        begin
            m_off = '0; m_pos = '0; m_rlen = '0;
            m_lba = '0; m_size = '0; m_flags = '0; m_nlen = '0;
            m_skip = 1'b0;
            m_active = 1'b1;
        end
        if (!m_active)
        begin
            return 1'b0;
        end
        off = m_off;
        sz  = m_dsize;
        if (m_skip)
        begin
        end
        else if (m_pos == 0)
        begin
            if (off >= sz)
            begin
                return close_scan(STATUS_NOT_FOUND, 1'b0, r);
            end
            if (b == 0)
            begin
                bnd = (off / SECTOR_DATA_BYTES + 1) * SECTOR_DATA_BYTES;
                if (bnd >= sz)
                begin
                    return close_scan(STATUS_NOT_FOUND, 1'b0, r);
                end
                m_skip = 1'b1;
            end
            else if (b < MIN_RECORD_LEN || off + b > sz)
            begin
                return close_scan(STATUS_BAD, 1'b0, r);
            end
            else
            begin
                m_rlen = b;
                m_pos  = 8'd1;
            end
        end
        else
        begin
            p = m_pos;
            if (p >= 2 && p <= 5)
            begin
                if (p == 2) m_lba = {24'd0, b};
                else        m_lba[(p-2)*8 +: 8] = b;
            end
            else if (p >= 10 && p <= 13)
            begin
                if (p == 10) m_size = {24'd0, b};
                else         m_size[(p-10)*8 +: 8] = b;
            end
            else if (p == 25)
            begin
                m_flags = b;
            end
            else if (p == 32)
            begin
                m_nlen = b;
            end
            else if (p >= NAME_FIELD_POS)
            begin
                m_names[p - NAME_FIELD_POS] = b;
            end
            p++;
            if (p >= m_rlen)
            begin
                m_pos = 8'd0;
                if (int'(m_nlen) + NAME_FIELD_POS <= int'(m_rlen) && name_hit())
                begin
                    return close_scan(STATUS_FOUND, 1'b1, r);
                end
            end
            else
            begin
                m_pos = p;
            end
        end
        off++;
        m_off = off;
        if (m_skip && (off % SECTOR_DATA_BYTES) == 0)
        begin
            m_skip = 1'b0;
        end
        if (!m_skip && m_pos == 0 && off >= sz)
        begin
            return close_scan(STATUS_NOT_FOUND, 1'b0, r);
        end
        return 1'b0;
    endfunction

    // queue a word for sending and record what it should produce
    function automatic bit queue_word(input logic [7:0] b, input bit s,
                                      input bit typed = 1'b0,
                                      input status_t typed_st = STATUS_FOUND);
        lookup_t r;
        bit      got;
        tx_byte_q.push_back(b);
        tx_start_q.push_back(s);
        got = predict_lookup(b, s, r);
        if (got)
        begin
            if (typed)
            begin
                r = '0;
                r.st = typed_st;
            end
            lookup_q.push_back(r);
        end
        return got;
    endfunction

    function automatic logic [7:0] name_char();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) return 8'(("A" + $urandom_range(0, 25)));
        if (k < 7) return 8'(("a" + $urandom_range(0, 25)));
        if (k < 9) return 8'(("0" + $urandom_range(0, 9)));
        return 8'($urandom_range(0, 255));
    endfunction

    // build one directory scan of records with random content
    function automatic void build_scan(input bit allow_abort);
        logic [7:0] nm [64];
        logic [7:0] b;
        bit   done;
        bit   first;
        int   k;
        int   nl;
        int   len;
        int   cl;
        int   nfield;
        done  = 1'b0;
        first = 1'b1;
        while (!done)
        begin
            k = $urandom_range(0, 99);
            if (!first && m_skip)
            begin
                done = queue_word(8'($urandom), 1'b0);
            end
            else if (k < 4)
            begin
                done = queue_word(8'd0, first);
                first = 1'b0;
            end
            else if (k < 10)
            begin
                done = queue_word(8'($urandom_range(1, 33)), first);
                first = 1'b0;
            end
            else if (k < 12 && !first && allow_abort)
            begin
                return;
            end
            else
            begin
                // name: a case-varied copy of the component, or random bytes
                if ($urandom_range(0, 99) < 40)
                begin
                    cl = (m_clen > MAX_COMPONENT_CHARS) ? MAX_COMPONENT_CHARS : m_clen;
                    if (cl > 2 && comp_char(cl-2) == CH_SEMI && comp_char(cl-1) == CH_ONE)
                    begin
                        cl -= 2;
                    end
                    nl = 0;
                    for (int i = 0; i < cl; i++)
                    begin
                        b = comp_char(i);
                        if ($urandom_range(0, 1) && fold_case(b) != b)
                        begin
                            b = fold_case(b);
                        end
                        else if ($urandom_range(0, 1) && b >= "A" && b <= "Z")
                        begin
                            b = b + 8'd32;
                        end
                        nm[nl++] = b;
                    end
                    if ($urandom_range(0, 1))
                    begin
                        nm[nl++] = CH_SEMI;
                        nm[nl++] = CH_ONE;
                    end
                    repeat ($urandom_range(0, 2))
                    begin
                        nm[nl++] = CH_SPACE;
                    end
                end
                else
                begin
                    nl = $urandom_range(0, 40);
                    for (int i = 0; i < nl; i++)
                    begin
                        nm[i] = name_char();
                    end
                end
                len = NAME_FIELD_POS + nl + $urandom_range(0, 12);
                if (len < MIN_RECORD_LEN) len = MIN_RECORD_LEN;
                if ($urandom_range(0, 19) == 0) len = 255;
                nfield = nl;
                if ($urandom_range(0, 14) == 0)
                begin
                    nfield = len - NAME_FIELD_POS + $urandom_range(1, 5);
                end
                done = queue_word(8'(len), first);
                first = 1'b0;
                for (int p = 1; p < len && !done; p++)
                begin
                    if (p == 32)
                    begin
                        b = 8'(nfield);
                    end
                    else if (p >= NAME_FIELD_POS && p - NAME_FIELD_POS < nl)
                    begin
                        b = nm[p - NAME_FIELD_POS];
                    end
                    else
                    begin
                        b = 8'($urandom);
                    end
                    done = queue_word(b, 1'b0);
                end
            end
        end
        // stray words after the scan has ended are ignored
        if ($urandom_range(0, 4) == 0)
        begin
            void'(queue_word(8'($urandom), 1'b0));
        end
    endfunction

    // drive queued words, with random gaps unless calm is set
    task automatic send_queued();
        while (tx_byte_q.size() != 0)
        begin
            if (!calm && $urandom_range(0, 99) < 35)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid   <= 1'b1;
            data_byte  <= tx_byte_q.pop_front();
            start_scan <= tx_start_q.pop_front();
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            n_bytes++;
        end
    endtask

    // drop valid and wait until the block has nothing left to do
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lookup_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CHARS_A: m_chars[63:0]    = val;
            REG_CHARS_B: m_chars[127:64]  = val;
            REG_CHARS_C: m_chars[191:128] = val;
            REG_CHARS_D: m_chars[255:192] = val;
            REG_LENGTH:  m_clen  = val[5:0];
            REG_DIRSIZE: m_dsize = val[30:0];
            default: ;
        endcase
    endtask

    // new component and directory size for one phase
    task automatic new_setting();
        logic [255:0] chars;
        int cl;
        int k;
        for (int i = 0; i < 8; i++)
        begin
            chars[i*32 +: 32] = $urandom;
        end
        k = $urandom_range(0, 29);
        if (k < 3)      cl = MAX_COMPONENT_CHARS;
        else if (k < 5) cl = 0;
        else if (k < 7) cl = 63;
        else            cl = $urandom_range(1, 32);
        for (int i = 0; i < 32 && i < cl; i++)
        begin
            if ($urandom_range(0, 9) < 8) chars[i*8 +: 8] = name_char();
        end
        if (cl > 2 && cl <= 32 && $urandom_range(0, 2) == 0)
        begin
            chars[(cl-2)*8 +: 8] = CH_SEMI;
            chars[(cl-1)*8 +: 8] = CH_ONE;
        end
        write_reg(REG_CHARS_A, chars[63:0]);
        write_reg(REG_CHARS_B, chars[127:64]);
        write_reg(REG_CHARS_C, chars[191:128]);
        write_reg(REG_CHARS_D, chars[255:192]);
        write_reg(REG_LENGTH, 64'(cl));
        k = $urandom_range(0, 11);
        if (k == 0)      write_reg(REG_DIRSIZE, 64'h7FFF_FFFF);
        else if (k == 1) write_reg(REG_DIRSIZE, 64'(SECTOR_DATA_BYTES + $urandom_range(1, 1200)));
        else             write_reg(REG_DIRSIZE, {$urandom, $urandom} | 64'h1);
        if (k > 1)
        begin
            write_reg(REG_DIRSIZE, 64'($urandom_range(100, 900)));
        end
    endtask

    // directed rows, default registers unless a row sets the size
    stim_row_t stim_rows [] = '{
        '{0, 31'd0, 8'h05, 1, 1, STATUS_BAD},
        '{0, 31'd0, 8'h00, 0, 0, STATUS_FOUND},
        '{0, 31'd0, 8'hFF, 0, 0, STATUS_FOUND},
        '{0, 31'd0, 8'h00, 1, 1, STATUS_NOT_FOUND},
        '{0, 31'd0, 8'd33, 1, 1, STATUS_BAD},
        '{0, 31'd0, 8'd34, 1, 0, STATUS_FOUND},
        '{0, 31'd0, 8'hA5, 0, 0, STATUS_FOUND},
        '{0, 31'd0, 8'd1,  1, 1, STATUS_BAD},
        '{0, 31'd0, 8'hFF, 1, 0, STATUS_FOUND},
        '{0, 31'd0, 8'h00, 1, 1, STATUS_NOT_FOUND},
        '{1, 31'd1, 8'h00, 0, 0, STATUS_FOUND},
        '{0, 31'd0, 8'h00, 1, 1, STATUS_NOT_FOUND},
        '{0, 31'd0, 8'd34, 1, 1, STATUS_BAD},
        '{1, 31'd0, 8'h00, 0, 0, STATUS_FOUND},
        '{0, 31'd0, 8'h07, 1, 1, STATUS_NOT_FOUND},
        '{1, 31'h7FFF_FFFF, 8'h00, 0, 0, STATUS_FOUND},
        '{0, 31'd0, 8'hFF, 1, 0, STATUS_FOUND},
        '{0, 31'd0, 8'd20, 1, 1, STATUS_BAD}
    };

    // receiver: random ready (always ready when calm), one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // lookup checker
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_lookups++;
            if (lookup_q.size() == 0)
            begin
                $display("%0t: unexpected lookup status %0d", $time, scan_status);
                n_errors++;
            end
            else
            begin
                e = lookup_q.pop_front();
                if (e.st == STATUS_FOUND) n_found++;
                if (scan_status != e.st)
                begin
                    $display("%0t: scan_status expected %0d actual %0d", $time, e.st, scan_status);
                    n_errors++;
                end
                if (extent_lba != e.lba)
                begin
                    $display("%0t: extent_lba expected %h actual %h", $time, e.lba, extent_lba);
                    n_errors++;
                end
                if (extent_size != e.size)
                begin
                    $display("%0t: extent_size expected %h actual %h", $time, e.size,
                             extent_size);
                    n_errors++;
                end
                if (file_flags != e.flags)
                begin
                    $display("%0t: file_flags expected %h actual %h", $time, e.flags,
                             file_flags);
                    n_errors++;
                end
            end
        end
    end

    // main stimulus
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        data_byte  = '0;
        start_scan = 1'b0;
        cycles     = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        m_chars = '0; m_clen = 6'd1; m_dsize = 31'd2048;
        m_off = '0; m_pos = '0; m_rlen = '0; m_lba = '0; m_size = '0;
        m_flags = '0; m_nlen = '0; m_skip = 1'b0; m_active = 1'b0;
        foreach (m_names[i]) m_names[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_size)
            begin
                send_queued();
                wait_idle();
                write_reg(REG_DIRSIZE, 64'(stim_rows[i].size_val));
            end
            else
            begin
                void'(queue_word(stim_rows[i].b, stim_rows[i].s, stim_rows[i].typed,
                                 stim_rows[i].st));
            end
        end
        send_queued();

        // random phases of well-formed directories with noise mixed in
        while (n_bytes < 2000 || n_phases < 3)
        begin
            wait_idle();
            new_setting();
            n_phases++;
            calm = (n_phases == 2);
            if (n_phases == 1) hold_req = 1'b1;
            repeat ($urandom_range(0, 1))
            begin
                build_scan(1'b1);
                n_scans++;
            end
            build_scan(1'b0);
            n_scans++;
            send_queued();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        @(posedge clk);
        while (lookup_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words over %0d scans in %0d settings", n_bytes, n_scans, n_phases);
        $display("checked %0d lookups, %0d of them found", n_lookups, n_found);
        if (n_errors == 0)
        begin
            $display("iso9660_directory_lookup regression: pass");
        end
        else
        begin
            $display("iso9660_directory_lookup regression: fail");
        end
        $finish;
    end

endmodule

// ----- iso9660_directory_lookup.f -----
+incdir+rtl/core
rtl/core/dlk_pkg.sv
rtl/core/dlk_cfg_regs.sv
rtl/core/dlk_name_ram.sv
rtl/core/iso9660_directory_lookup.sv
tb/tb_iso9660_directory_lookup.sv
